[rtl/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the WAV stream to DAC sample block
// Beat types for both channels, result kind codes, RIFF tags and queue depth.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Input beat: one byte of the WAV file plus sideband flags
  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
    logic       abort_request;
  } in_beat_t;

  // Output beat: one result
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  dac_level;
    logic [31:0] rate_hz;
    logic        last_of_run;
  } out_beat_t;

  // Up to two results caused by one input beat
  typedef struct packed {
    logic [1:0] num;
    out_beat_t  r0;
    out_beat_t  r1;
  } res_pair_t;

  // Result kinds
  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_OK      = 2'd1;
  localparam logic [1:0] KIND_FMT_ERR = 2'd2;
  localparam logic [1:0] KIND_ABORT   = 2'd3;

  localparam logic [7:0] IDLE_LEVEL = 8'd127;

  // Four-character tags, first character in the low byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // 16-bit to 8-bit bias
  localparam logic [16:0] PCM16_BIAS = 17'd32767;

  // Result queue depth (at least two)
  localparam int unsigned QUEUE_DEPTH = 4;

  // Byte i of a tag
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    return tag[{idx, 3'b000} +: 8];
  endfunction

  // One result with last_of_run clear
  function automatic out_beat_t make_res(input logic [1:0] kind, input logic [7:0] level,
                                         input logic [31:0] rate);
    out_beat_t r;
    r.kind        = kind;
    r.dac_level   = level;
    r.rate_hz     = rate;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

[rtl/wsd_parser.sv]
// ----------------------------------------------------------------------------
// wsd_parser: RIFF WAV header walk and sample conversion
// Holds the parse state; works out the results of an accepted beat in one
// pass and updates the state at the same edge.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  wsd_pkg::in_beat_t beat_i,
  output wsd_pkg::res_pair_t res_o
);
  import wsd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SEARCH,
    PH_SAMPLE,
    PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] off_q, off_d;
  logic [31:0] cstart_q, cstart_d;
  logic [31:0] sgather_q, sgather_d;
  logic        idm_q, idm_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [1:0]  sbi_q, sbi_d;
  logic [7:0]  hold_q, hold_d;

  // Next state and results for the beat on the input
  always_comb begin
    logic [7:0]  b;
    logic        eof;
    logic        ab;
    logic [32:0] off_p1;
    logic [31:0] sg_shift;
    logic [32:0] nx_hdr;
    logic [32:0] diff;
    logic        in_chunk_hdr;
    logic [2:0]  d;
    logic [33:0] nx_chunk;
    logic        err;
    logic        entered;
    logic        wide;
    logic        stereo;
    logic [2:0]  frame;
    logic [2:0]  idx_n;
    logic [16:0] biased;
    logic        produced;
    logic [7:0]  level;
    res_pair_t   res;

    b   = beat_i.file_byte;
    eof = beat_i.end_of_file;
    ab  = beat_i.abort_request;

    phase_d   = phase_q;
    off_d     = off_q;
    cstart_d  = cstart_q;
    sgather_d = sgather_q;
    idm_d     = idm_q;
    chan_d    = chan_q;
    rate_d    = rate_q;
    bits_d    = bits_q;
    sbi_d     = sbi_q;
    hold_d    = hold_q;

    err      = 1'b0;
    entered  = 1'b0;
    produced = 1'b0;
    level    = '0;
    res      = '0;

    off_p1   = {1'b0, off_q} + 33'd1;
    sg_shift = {b, sgather_q[31:8]};
    nx_hdr   = 33'd20 + {1'b0, sg_shift};
    diff     = {1'b0, off_q} - {1'b0, cstart_q};
    in_chunk_hdr = !diff[32] && (diff[31:3] == 29'd0);
    d        = diff[2:0];
    nx_chunk = {1'b0, off_p1} + {2'b00, sg_shift};

    // Format fields, captured at fixed offsets outside the done phase
    if (phase_q != PH_DONE) begin
      if (off_q == 32'd22) begin
        chan_d[7:0] = b;
      end else if (off_q == 32'd23) begin
        chan_d[15:8] = b;
      end else if (off_q[31:2] == 30'd6) begin
        rate_d[{off_q[1:0], 3'b000} +: 8] = b;
      end else if (off_q == 32'd34) begin
        bits_d[7:0] = b;
      end else if (off_q == 32'd35) begin
        bits_d[15:8] = b;
      end
    end

    // Sample unpacking uses the freshly captured format
    wide   = (bits_d == 16'd16);
    stereo = (chan_d == 16'd2);
    frame  = wide ? (stereo ? 3'd4 : 3'd2) : (stereo ? 3'd2 : 3'd1);
    idx_n  = {1'b0, sbi_q} + 3'd1;
    biased = {1'b0, b, hold_q} + PCM16_BIAS;

    unique case (phase_q)
      PH_HEADER: begin
        if (off_q[31:2] == 30'd0) begin
          err = (b != tag_byte(TAG_RIFF, off_q[1:0]));
        end else if (off_q[31:2] == 30'd2) begin
          err = (b != tag_byte(TAG_WAVE, off_q[1:0]));
        end else if (off_q[31:2] == 30'd3) begin
          err = (b != tag_byte(TAG_FMT, off_q[1:0]));
        end else if (off_q[31:2] == 30'd4) begin
          sgather_d = sg_shift;
          if (off_q[1:0] == 2'd3) begin
            if (nx_hdr[32]) begin
              err = 1'b1;
            end else begin
              cstart_d = nx_hdr[31:0];
              phase_d  = PH_SEARCH;
            end
          end
        end
      end
      PH_SEARCH: begin
        if (in_chunk_hdr) begin
          if (d == 3'd0) begin
            idm_d = (b == tag_byte(TAG_DATA, 2'd0));
          end else if (!d[2]) begin
            idm_d = idm_q & (b == tag_byte(TAG_DATA, d[1:0]));
          end else begin
            sgather_d = sg_shift;
          end
          if (d == 3'd7) begin
            if (idm_q) begin
              phase_d = PH_SAMPLE;
              sbi_d   = 2'd0;
              entered = 1'b1;
            end else if (nx_chunk[33:32] != 2'd0) begin
              err = 1'b1;
            end else begin
              cstart_d = nx_chunk[31:0];
            end
          end
        end
      end
      PH_SAMPLE: begin
        if (wide) begin
          if (sbi_q == 2'd0) begin
            hold_d = b;
          end else if (sbi_q == 2'd1) begin
            level    = biased[15:8];
            produced = 1'b1;
          end
        end else if (sbi_q == 2'd0) begin
          level    = b;
          produced = 1'b1;
        end
        sbi_d = (idx_n >= frame) ? 2'd0 : idx_n[1:0];
        if (ab) begin
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (err) begin
      phase_d = PH_DONE;
    end

    // Result assembly
    if (phase_q == PH_SAMPLE) begin
      if (produced) begin
        res.r0 = make_res(KIND_SAMPLE, level, rate_d);
        if (ab) begin
          res.r1  = make_res(KIND_ABORT, 8'd0, rate_d);
          res.num = 2'd2;
        end else if (eof) begin
          res.r1  = make_res(KIND_OK, IDLE_LEVEL, rate_d);
          res.num = 2'd2;
        end else begin
          res.num = 2'd1;
        end
      end else if (ab) begin
        res.r0  = make_res(KIND_ABORT, 8'd0, rate_d);
        res.num = 2'd1;
      end else if (eof) begin
        res.r0  = make_res(KIND_OK, IDLE_LEVEL, rate_d);
        res.num = 2'd1;
      end
    end else if (phase_q != PH_DONE) begin
      if (err) begin
        res.r0  = make_res(KIND_FMT_ERR, 8'd0, rate_d);
        res.num = 2'd1;
      end else if (eof) begin
        res.r0  = entered ? make_res(KIND_OK, IDLE_LEVEL, rate_d)
                          : make_res(KIND_FMT_ERR, 8'd0, rate_d);
        res.num = 2'd1;
      end
    end
    if (res.num == 2'd1) begin
      res.r0.last_of_run = 1'b1;
    end
    if (res.num == 2'd2) begin
      res.r1.last_of_run = 1'b1;
    end
    res_o = res;

    // Saturating offset, frozen in the done phase
    if (phase_q != PH_DONE && !off_p1[32]) begin
      off_d = off_p1[31:0];
    end

    // End of file returns everything to the reset values
    if (eof) begin
      phase_d   = PH_HEADER;
      off_d     = '0;
      cstart_d  = '0;
      sgather_d = '0;
      idm_d     = 1'b1;
      chan_d    = '0;
      rate_d    = '0;
      bits_d    = '0;
      sbi_d     = '0;
      hold_d    = '0;
    end
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      off_q     <= '0;
      cstart_q  <= '0;
      sgather_q <= '0;
      idm_q     <= 1'b1;
      chan_q    <= '0;
      rate_q    <= '0;
      bits_q    <= '0;
      sbi_q     <= '0;
      hold_q    <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      off_q     <= off_d;
      cstart_q  <= cstart_d;
      sgather_q <= sgather_d;
      idm_q     <= idm_d;
      chan_q    <= chan_d;
      rate_q    <= rate_d;
      bits_q    <= bits_d;
      sbi_q     <= sbi_d;
      hold_q    <= hold_d;
    end
  end

endmodule

[rtl/wsd_res_queue.sv]
// ----------------------------------------------------------------------------
// wsd_res_queue: result queue
// Takes up to two results per cycle and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module wsd_res_queue #(
  parameter int unsigned Depth = wsd_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wsd_pkg::res_pair_t  res_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wsd_pkg::out_beat_t  out_data_o
);
  import wsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_beat_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr1;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      n_push;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign n_push      = push_i ? res_i.num : 2'd0;
  assign wr1         = ptr_inc(wr_q);
  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d = wr_q;
    if (n_push == 2'd1) begin
      wr_d = wr1;
    end else if (n_push == 2'd2) begin
      wr_d = ptr_inc(wr1);
    end
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Result storage
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= res_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr1] <= res_i.r1;
    end
  end

endmodule

[rtl/wav_stream_to_dac_samples.sv]
// ----------------------------------------------------------------------------
// wav_stream_to_dac_samples: RIFF WAV byte stream to 8-bit DAC levels
// Parses the header, walks chunks to the data chunk and turns the left
// channel samples into DAC levels, with status at end of file, error or abort.
// ----------------------------------------------------------------------------
//   channel | handshake                  | beat
//   in      | in_valid_i / in_ready_o    | in_data_i  : file byte, end, abort
//   out     | out_valid_o / out_ready_i  | out_data_o : kind, level, rate, last
//
// One file byte is taken per cycle while the queue has room; its results are
// written into the queue at the accepting edge and leave it behind earlier ones.
// A beat that causes two results hands them out as two output beats; the queue
// depth (QueueDepth, at least two free entries to take a beat) sets how far
// the input runs ahead of a stalled output.
// Reset puts the parser in the header phase with an empty queue.
// ----------------------------------------------------------------------------
module wav_stream_to_dac_samples #(
  parameter int unsigned QueueDepth = wsd_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wsd_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wsd_pkg::out_beat_t out_data_o
);
  import wsd_pkg::*;

  logic      accept;
  res_pair_t res;

  assign accept = in_valid_i && in_ready_o;

  // Parse state and per-byte results
  wsd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_data_i),
    .res_o    (res)
  );

  // Result queue
  wsd_res_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/wsd_checker.sv]
// ----------------------------------------------------------------------------
// wsd_checker: port-level checks for wav_stream_to_dac_samples
// Watches the result channel for stalls, status levels and paired results.
// ----------------------------------------------------------------------------
module wsd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input wsd_pkg::out_beat_t out_data_o
);
  import wsd_pkg::*;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed under stall");

  // Finish status carries the idle level
  a_ok_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_OK |-> out_data_o.dac_level == IDLE_LEVEL)
    else $error("finish status without idle level");

  // Error and abort carry level zero
  a_err_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_FMT_ERR || out_data_o.kind == KIND_ABORT)
    |-> out_data_o.dac_level == 8'd0)
    else $error("error or abort with nonzero level");

  // A status always closes the run of its byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_SAMPLE |-> out_data_o.last_of_run)
    else $error("status result not marked last");

  // A sample followed by a status has that status ready right behind it
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.kind == KIND_SAMPLE && !out_data_o.last_of_run
    |=> out_valid_o && out_data_o.kind != KIND_SAMPLE)
    else $error("second result of a byte missing");

endmodule

bind wav_stream_to_dac_samples wsd_checker u_wsd_checker (.*);
